// ----- hw/rtl/spo2_pkg.sv -----
// Package for the SpO2 estimator: constants and the SpO2 lookup table.
// No dependencies.
`timescale 1ns / 1ps
package spo2_pkg;
  localparam int unsigned TableEntries = 43;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned SumBits = 48;
  localparam int unsigned HighKnee = 66;
  localparam int unsigned LowKnee = 50;
  localparam int unsigned RatioScale = 100;
  localparam logic [7:0] BeatsReset = 8'd3;
  localparam int unsigned IdxBits = 6;

  function automatic logic [6:0] spo2_lut(input logic [IdxBits-1:0] idx);
    logic [6:0] v;
    if (idx < 6'd4) v = 7'd100;
    else if (idx < 6'd10) v = 7'd99;
    else if (idx < 6'd15) v = 7'd98;
    else if (idx < 6'd21) v = 7'd97;
    else if (idx < 6'd27) v = 7'd96;
    else if (idx < 6'd33) v = 7'd95;
    else if (idx < 6'd38) v = 7'd94;
    else v = 7'd93;
    return v;
  endfunction
endpackage

// ----- hw/rtl/pulse_oximeter_spo2_estimator_core.sv -----
// SpO2 estimator top level: front accumulator, one-entry queue, compute engine.
// Depends on spo2_pkg, spo2_front, spo2_engine.
//
// Input channel: in_valid/in_ready with ir, red AC samples and a beat flag.
// Output channel: out_valid/out_ready with the held SpO2 and an update flag.
// Every request yields exactly one result.
// A request that triggers an estimate runs two 48-step serial divides, two
// Q16 log2 evaluations (16 squaring rounds, each through S_SQ0 to S_SQ3) and a
// 29-step ratio divide; an IR mean of at most 1 skips all but the two divides.
// The front accepts the next request once the queue entry moves to the engine.
// Reset clears sums, counts, held SpO2 and sets beats_per_estimate to 3.
// A stalled receiver holds the result; the engine and then the front stall.
`timescale 1ns / 1ps
module pulse_oximeter_spo2_estimator_core #(
  parameter int unsigned SampleBits = spo2_pkg::SampleBitsDef,
  parameter int unsigned CountBits = spo2_pkg::CountBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic in_valid,
  output logic in_ready,
  input  logic [SampleBits-1:0] ir_ac_sample_i,
  input  logic [SampleBits-1:0] red_ac_sample_i,
  input  logic beat_seen_i,
  output logic out_valid,
  input  logic out_ready,
  output logic [6:0] spo2_percent_o,
  output logic estimate_updated_o
);
  import spo2_pkg::*;
  logic [7:0] beats_q;
  logic rv, rr, re;
  logic [SumBits-1:0] ri, rd;
  logic [CountBits-1:0] rn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) beats_q <= BeatsReset;
    else if (cfg_we_i) beats_q <= cfg_wdata_i;
  end

  spo2_front #(.SampleBits(SampleBits), .CountBits(CountBits)) u_front (
    .clk_i, .rst_ni, .beats_i(beats_q), .in_valid, .in_ready,
    .ir_i(ir_ac_sample_i), .red_i(red_ac_sample_i), .beat_i(beat_seen_i),
    .req_valid_o(rv), .req_ready_i(rr), .req_est_o(re), .req_ir_o(ri),
    .req_red_o(rd), .req_n_o(rn)
  );

  spo2_engine #(.CountBits(CountBits)) u_engine (
    .clk_i, .rst_ni, .req_valid_i(rv), .req_ready_o(rr), .req_est_i(re),
    .req_ir_i(ri), .req_red_i(rd), .req_n_i(rn), .out_valid_o(out_valid),
    .out_ready_i(out_ready), .spo2_o(spo2_percent_o), .upd_o(estimate_updated_o)
  );
endmodule

// ----- hw/rtl/spo2_front.sv -----
// Front end: accumulates squared samples and counts, decides on an estimate.
// Depends on spo2_pkg.
`timescale 1ns / 1ps
module spo2_front #(
  parameter int unsigned SampleBits = 16,
  parameter int unsigned CountBits = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [7:0] beats_i,
  input  logic in_valid,
  output logic in_ready,
  input  logic [SampleBits-1:0] ir_i,
  input  logic [SampleBits-1:0] red_i,
  input  logic beat_i,
  output logic req_valid_o,
  input  logic req_ready_i,
  output logic req_est_o,
  output logic [spo2_pkg::SumBits-1:0] req_ir_o,
  output logic [spo2_pkg::SumBits-1:0] req_red_o,
  output logic [CountBits-1:0] req_n_o
);
  import spo2_pkg::*;
  localparam int unsigned SqBits = 2 * SampleBits;

  logic [SumBits-1:0] ir_sum_q, red_sum_q;
  logic [CountBits-1:0] n_q;
  logic [7:0] beat_q;
  logic full_q, est_q;
  logic [SumBits-1:0] qir_q, qred_q;
  logic [CountBits-1:0] qn_q;

  logic [SampleBits-1:0] ir_mag, red_mag;
  logic [SqBits-1:0] ir_sq, red_sq;
  logic [SumBits:0] ir_add, red_add;
  logic [SumBits-1:0] ir_new, red_new;
  logic [CountBits-1:0] n_new;
  logic [7:0] beat_new;
  logic fire, trig;

  assign ir_mag = ir_i[SampleBits-1] ? (~ir_i + 1'b1) : ir_i;
  assign red_mag = red_i[SampleBits-1] ? (~red_i + 1'b1) : red_i;
  assign ir_sq = SqBits'(ir_mag) * SqBits'(ir_mag);
  assign red_sq = SqBits'(red_mag) * SqBits'(red_mag);
  assign ir_add = {1'b0, ir_sum_q} + (SumBits + 1)'(ir_sq);
  assign red_add = {1'b0, red_sum_q} + (SumBits + 1)'(red_sq);
  assign ir_new = ir_add[SumBits] ? '1 : ir_add[SumBits-1:0];
  assign red_new = red_add[SumBits] ? '1 : red_add[SumBits-1:0];
  assign n_new = (&n_q) ? n_q : n_q + 1'b1;
  assign beat_new = (&beat_q) ? beat_q : beat_q + 8'd1;
  assign trig = beat_i && (beat_new >= beats_i);

  assign in_ready = !full_q || req_ready_i;
  assign fire = in_valid && in_ready;
  assign req_valid_o = full_q;
  assign req_est_o = est_q;
  assign req_ir_o = qir_q;
  assign req_red_o = qred_q;
  assign req_n_o = qn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_sum_q <= '0;
      red_sum_q <= '0;
      n_q <= '0;
      beat_q <= '0;
      full_q <= 1'b0;
      est_q <= 1'b0;
    end else begin
      if (req_ready_i) full_q <= 1'b0;
      if (fire) begin
        full_q <= 1'b1;
        est_q <= trig;
        qir_q <= ir_new;
        qred_q <= red_new;
        qn_q <= n_new;
        if (trig) begin
          ir_sum_q <= '0;
          red_sum_q <= '0;
          n_q <= '0;
          beat_q <= '0;
        end else begin
          ir_sum_q <= ir_new;
          red_sum_q <= red_new;
          n_q <= n_new;
          if (beat_i) beat_q <= beat_new;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/spo2_engine.sv -----
// Back end: serial divides, Q16 log2 by squaring, ratio and table lookup.
// Depends on spo2_pkg.
`timescale 1ns / 1ps
module spo2_engine #(
  parameter int unsigned CountBits = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  logic req_est_i,
  input  logic [spo2_pkg::SumBits-1:0] req_ir_i,
  input  logic [spo2_pkg::SumBits-1:0] req_red_i,
  input  logic [CountBits-1:0] req_n_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [6:0] spo2_o,
  output logic upd_o
);
  import spo2_pkg::*;
  localparam int unsigned DivW = SumBits + 8;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_LOGI, S_MSB, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_SQN, S_RDIV, S_DONE
  } state_e;

  state_e st_q;
  logic [6:0] held_q;
  logic out_v_q, upd_q;
  logic [DivW-1:0] num_q, den_q, quo_q, rem_q;
  logic [5:0] cnt_q;
  logic [SumBits-1:0] irm_q, redm_q, x_q;
  logic [21:0] li_q, res_q;
  logic [4:0] bit_q;
  logic which_q;
  logic [31:0] m_q;
  logic [15:0] p0_q, p1_q;
  logic [31:0] p3_q;
  logic [5:0] msb_c;
  logic [DivW:0] rsh;

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < SumBits; i++) if (x_q[i]) msb_c = 6'(i);
  end
  assign rsh = {rem_q, num_q[DivW-1]};

  assign req_ready_o = (st_q == S_IDLE) && (!out_v_q || out_ready_i);
  assign out_valid_o = out_v_q;
  assign spo2_o = held_q;
  assign upd_o = upd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      held_q <= '0;
      out_v_q <= 1'b0;
      upd_q <= 1'b0;
    end else begin
      if (out_ready_i) out_v_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (req_valid_i && req_ready_o) begin
            if (req_est_i) begin
              num_q <= {req_ir_i, (DivW - SumBits)'(0)};
              redm_q <= req_red_i;
              den_q <= DivW'((req_n_i == '0) ? CountBits'(1) : req_n_i);
              rem_q <= '0;
              cnt_q <= '0;
              which_q <= 1'b0;
              st_q <= S_DIV;
            end else begin
              out_v_q <= 1'b1;
              upd_q <= 1'b0;
            end
          end
        end
        S_DIV: begin
          if (rsh >= {1'b0, den_q}) rem_q <= DivW'(rsh - {1'b0, den_q});
          else rem_q <= rsh[DivW-1:0];
          num_q <= {num_q[DivW-2:0], (rsh >= {1'b0, den_q})};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(SumBits - 1)) begin
            if (!which_q) begin
              which_q <= 1'b1;
              cnt_q <= '0;
              rem_q <= '0;
              irm_q <= {num_q[SumBits-2:0], (rsh >= {1'b0, den_q})};
              num_q <= {redm_q, (DivW - SumBits)'(0)};
            end else begin
              redm_q <= {num_q[SumBits-2:0], (rsh >= {1'b0, den_q})};
              which_q <= 1'b0;
              st_q <= S_LOGI;
            end
          end
        end
        S_LOGI: begin
          if (irm_q <= SumBits'(1)) begin
            held_q <= '0;
            upd_q <= 1'b1;
            out_v_q <= 1'b1;
            st_q <= S_IDLE;
          end else begin
            x_q <= irm_q;
            st_q <= S_MSB;
          end
        end
        S_MSB: begin
          res_q <= {msb_c, 16'd0};
          if (msb_c >= 6'd30) m_q <= 32'(x_q >> (msb_c - 6'd30));
          else m_q <= 32'(x_q << (6'd30 - msb_c));
          bit_q <= 5'd15;
          if (x_q == '0) begin
            res_q <= '0;
            st_q <= S_SQN;
            bit_q <= 5'd31;
          end else st_q <= S_SQ0;
        end
        S_SQ0: begin
          p0_q <= m_q[15:0];
          p3_q <= 32'(m_q[31:16]) * 32'(m_q[31:16]);
          p1_q <= 16'(m_q[15:0]);
          st_q <= S_SQ1;
        end
        S_SQ1: begin
          // m*m = H^2<<32 + 2HL<<16 + L^2
          x_q <= SumBits'(32'(m_q[31:16]) * 32'(p1_q));
          st_q <= S_SQ2;
        end
        S_SQ2: begin
          x_q <= SumBits'({x_q[SumBits-2:0], 1'b0});
          m_q <= 32'(32'(p0_q) * 32'(p0_q));
          st_q <= S_SQ3;
        end
        S_SQ3: begin
          m_q <= 32'(({p3_q, 32'd0} + {x_q[47:0], 16'd0} + {32'd0, m_q}) >> 30);
          if (((({p3_q, 32'd0} + {x_q[47:0], 16'd0} + {32'd0, m_q}) >> 30) >> 31) != 0) begin
            m_q <= 32'((({p3_q, 32'd0} + {x_q[47:0], 16'd0} + {32'd0, m_q}) >> 30) >> 1);
            res_q[bit_q[3:0]] <= 1'b1;
          end
          if (bit_q == 5'd0) st_q <= S_SQN;
          else begin
            bit_q <= bit_q - 5'd1;
            st_q <= S_SQ0;
          end
        end
        S_SQN: begin
          if (!which_q) begin
            li_q <= res_q;
            which_q <= 1'b1;
            x_q <= redm_q;
            st_q <= S_MSB;
          end else begin
            num_q <= {29'(res_q) * 29'(RatioScale), (DivW - 29)'(0)};
            den_q <= DivW'(li_q);
            rem_q <= '0;
            cnt_q <= '0;
            st_q <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (rsh >= {1'b0, den_q}) rem_q <= DivW'(rsh - {1'b0, den_q});
          else rem_q <= rsh[DivW-1:0];
          num_q <= {num_q[DivW-2:0], (rsh >= {1'b0, den_q})};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd28) begin
            quo_q <= {num_q[DivW-2:0], (rsh >= {1'b0, den_q})};
            if (rsh >= {1'b0, den_q}) rem_q <= DivW'(rsh - {1'b0, den_q});
            else rem_q <= rsh[DivW-1:0];
            st_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (quo_q > DivW'(HighKnee) || (quo_q == DivW'(HighKnee) && rem_q != '0)) begin
            held_q <= spo2_lut((quo_q - DivW'(HighKnee)) > DivW'(TableEntries - 1) ?
                      IdxBits'(TableEntries - 1) : IdxBits'(quo_q - DivW'(HighKnee)));
          end else if (quo_q > DivW'(LowKnee) ||
                       (quo_q == DivW'(LowKnee) && rem_q != '0)) begin
            held_q <= spo2_lut((quo_q - DivW'(LowKnee)) > DivW'(TableEntries - 1) ?
                      IdxBits'(TableEntries - 1) : IdxBits'(quo_q - DivW'(LowKnee)));
          end else held_q <= spo2_lut('0);
          which_q <= 1'b0;
          upd_q <= 1'b1;
          out_v_q <= 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- dv/pulse_oximeter_spo2_estimator_core_test.sv -----
// Self-checking testbench for the SpO2 estimator core: random and directed
// sample requests, a running predictor of the held SpO2, per-result checks.
// Depends on spo2_pkg and the pulse_oximeter_spo2_estimator_core RTL.
`timescale 1ns / 1ps
module pulse_oximeter_spo2_estimator_core_test;
  localparam int unsigned SampleBits = spo2_pkg::SampleBitsDef;
  localparam int unsigned CountBits = spo2_pkg::CountBitsDef;
  localparam logic [47:0] SumMax = '1;
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef struct packed {
    logic [6:0] spo2;
    logic       updated;
  } spo2_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SampleBits-1:0] ir_ac_sample_i = '0;
  logic [SampleBits-1:0] red_ac_sample_i = '0;
  logic beat_seen_i = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [6:0] spo2_percent_o;
  logic estimate_updated_o;

  pulse_oximeter_spo2_estimator_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid(in_valid), .in_ready(in_ready), .ir_ac_sample_i(ir_ac_sample_i),
    .red_ac_sample_i(red_ac_sample_i), .beat_seen_i(beat_seen_i),
    .out_valid(out_valid), .out_ready(out_ready), .spo2_percent_o(spo2_percent_o),
    .estimate_updated_o(estimate_updated_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [47:0] ir_sum, red_sum;
  logic [CountBits-1:0] n_samples;
  logic [7:0] n_beats, beats_cfg;
  logic [6:0] held;
  spo2_result_t spo2_expected[$];
  int errors = 0;
  bit idle_en = 1'b1;
  int hold_cycles = 0;

  function automatic logic [31:0] sample_square(logic [SampleBits-1:0] s);
    logic [SampleBits-1:0] mag;
    mag = s[SampleBits-1] ? (~s + 1'b1) : s;
    return 32'(mag) * 32'(mag);
  endfunction

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? SumMax : s[47:0];
  endfunction

  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int msb;
    logic [63:0] m, r;
    if (x == 0) return 64'd0;
    msb = 0;
    while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
    m = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
    r = 64'(msb) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] spo2_from_sums();
    logic [63:0] n, ir_mean, red_mean, li, num, whole, rem, idx;
    n = (n_samples == 0) ? 64'd1 : 64'(n_samples);
    ir_mean = 64'(ir_sum) / n;
    red_mean = 64'(red_sum) / n;
    if (ir_mean <= 1) return 7'd0;
    li = log2_fix(ir_mean);
    num = 64'(spo2_pkg::RatioScale) * log2_fix(red_mean);
    whole = num / li;
    rem = num % li;
    idx = 64'd0;
    if (whole > spo2_pkg::HighKnee || (whole == spo2_pkg::HighKnee && rem != 0))
      idx = whole - spo2_pkg::HighKnee;
    else if (whole > spo2_pkg::LowKnee || (whole == spo2_pkg::LowKnee && rem != 0))
      idx = whole - spo2_pkg::LowKnee;
    if (idx > spo2_pkg::TableEntries - 1) idx = 64'(spo2_pkg::TableEntries - 1);
    if (idx < 4) return 7'd100;
    if (idx < 10) return 7'd99;
    if (idx < 15) return 7'd98;
    if (idx < 21) return 7'd97;
    if (idx < 27) return 7'd96;
    if (idx < 33) return 7'd95;
    if (idx < 38) return 7'd94;
    return 7'd93;
  endfunction

  function automatic void predict_spo2(logic [SampleBits-1:0] ir,
                                       logic [SampleBits-1:0] red, logic beat);
    spo2_result_t r;
    r.updated = 1'b0;
    ir_sum = add_sat(ir_sum, sample_square(ir));
    red_sum = add_sat(red_sum, sample_square(red));
    if (n_samples != CountMax) n_samples++;
    if (beat) begin
      if (n_beats != 8'hFF) n_beats++;
      if (n_beats >= beats_cfg) begin
        held = spo2_from_sums();
        ir_sum = 0;
        red_sum = 0;
        n_samples = 0;
        n_beats = 0;
        r.updated = 1'b1;
      end
    end
    r.spo2 = held;
    spo2_expected.push_back(r);
  endfunction

  task automatic send_sample(logic [SampleBits-1:0] ir, logic [SampleBits-1:0] red,
                             logic beat);
    if (idle_en && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while (idle_en && $urandom_range(99) < 29);
    end
    in_valid <= 1'b1;
    ir_ac_sample_i <= ir;
    red_ac_sample_i <= red;
    beat_seen_i <= beat;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_spo2(ir, red, beat);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (spo2_expected.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_beats(logic [7:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    beats_cfg = v;
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_en && $urandom_range(99) < 29);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    spo2_result_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (spo2_expected.size() == 0) begin
        $error("unexpected result spo2=%0d", spo2_percent_o);
        errors++;
      end else begin
        e = spo2_expected.pop_front();
        if (spo2_percent_o !== e.spo2) begin
          $error("spo2_percent exp %0d got %0d", e.spo2, spo2_percent_o);
          errors++;
        end
        if (estimate_updated_o !== e.updated) begin
          $error("estimate_updated exp %0d got %0d", e.updated, estimate_updated_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [SampleBits-1:0] rand_sample(int amp);
    int v;
    v = $urandom_range(2 * amp) - amp;
    return SampleBits'(v);
  endfunction

  task automatic test_directed();
    send_sample(16'h7FFF, 16'h8000, 1'b0);
    send_sample(16'h8000, 16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 16'h0001, 1'b1);  // first beat, large samples
    send_sample(16'h0000, 16'h0000, 1'b0);
    send_sample(16'h0001, 16'hFFFF, 1'b0);
    send_sample(16'h0001, 16'h0000, 1'b1);  // second beat, small ir sample
    send_sample(16'd1000, 16'd0, 1'b0);
    send_sample(16'd1000, 16'd0, 1'b0);
    send_sample(16'd1000, 16'd0, 1'b1);     // third beat, estimate
    for (int i = 0; i < 3; i++) send_sample(16'd40, 16'd12000, i == 2);  // small ir, large red
    for (int i = 0; i < 3; i++) send_sample(16'd3000, 16'd500, i == 2);
    for (int i = 0; i < 3; i++) send_sample(16'h5555, 16'hAAAA, i == 2);
  endtask

  task automatic test_config_extremes();
    write_beats(8'd1);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(20000), rand_sample(20000), 1'b1);
    write_beats(8'd0);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(9000), rand_sample(9000), 1'b1);
    write_beats(8'd255);
    // a long accumulation whose beats stay below the configured count
    for (int i = 0; i < 300; i++) send_sample(16'h8000, 16'h8000, 1'(i % 2));
    write_beats(8'd2);  // lowered below current count
    send_sample(16'd500, 16'd700, 1'b1);
  endtask

  task automatic test_random(int n_items);
    int amp_ir, amp_red;
    amp_ir = 2000;
    amp_red = 2000;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        amp_ir = $urandom_range(32767, 2);
        amp_red = $urandom_range(32767, 0);
      end
      if (i == n_items / 2) begin
        if (spo2_expected.size() == 0) write_beats(8'($urandom_range(6, 1)));
        else write_beats(8'($urandom_range(6, 1)));
      end
      idle_en = !(i >= 200 && i < 400);
      if ($urandom_range(9) == 0)
        send_sample(16'($urandom), 16'($urandom), 1'($urandom_range(1)));
      else
        send_sample(rand_sample(amp_ir), rand_sample(amp_red), $urandom_range(4) == 0);
    end
    idle_en = 1'b1;
  endtask

  task automatic test_back_pressure();
    hold_cycles = 600;
    for (int i = 0; i < 40; i++) send_sample(rand_sample(15000), rand_sample(15000),
                                             $urandom_range(2) == 0);
  endtask

  initial begin
    ir_sum = 0;
    red_sum = 0;
    n_samples = 0;
    n_beats = 0;
    held = 0;
    beats_cfg = spo2_pkg::BeatsReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    write_beats(8'd3);
    test_back_pressure();
    test_random(1000);
    drain();
    if (errors == 0) $display("[pulse_oximeter_spo2_estimator_core] OK");
    else $display("[pulse_oximeter_spo2_estimator_core] ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("[pulse_oximeter_spo2_estimator_core] ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/spo2_pkg.sv
hw/rtl/spo2_front.sv
hw/rtl/spo2_engine.sv
hw/rtl/pulse_oximeter_spo2_estimator_core.sv
dv/pulse_oximeter_spo2_estimator_core_test.sv
